// ===== hw/rtl/osen_pkg.sv =====
// Shared types and constants of the ordered set engine.
// Holds command codes, key type and the structs passed along the cell chain.
// Depends on nothing.
package osen_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;

	typedef logic [2:0] kind_t;
	typedef logic signed [KEY_BITS-1:0] key_t;

	localparam kind_t OP_INSERT = 3'd0;
	localparam kind_t OP_DELETE = 3'd1;
	localparam kind_t OP_MEMBER = 3'd2;
	localparam kind_t OP_MIN    = 3'd3;
	localparam kind_t OP_MAX    = 3'd4;
	localparam kind_t OP_PRED   = 3'd5;
	localparam kind_t OP_SUCC   = 3'd6;
	localparam kind_t OP_CLEAR  = 3'd7;

	// Broadcast to every cell in the execute cycle.
	typedef struct packed {
		logic ins_go;
		logic del_go;
		logic clr;
		key_t key;
	} cell_ctl_t;

	// What a cell shows to its neighbors and to the result picker.
	typedef struct packed {
		key_t key;
		logic valid;
		logic lt;
		logic eq;
	} cell_stat_t;

endpackage

// ===== hw/rtl/osen_if.sv =====
// Command and response channel interfaces of the ordered set engine.
// Depends on osen_pkg.
interface osen_cmd_if;
	logic            valid;
	logic            ready;
	osen_pkg::kind_t kind;
	osen_pkg::key_t  key;

	modport source (output valid, kind, key, input ready);
	modport sink (input valid, kind, key, output ready);
endinterface

interface osen_rsp_if;
	logic           valid;
	logic           ready;
	logic           answer_yes;
	osen_pkg::key_t value;
	logic           value_present;
	logic           table_full;

	modport source (output valid, answer_yes, value, value_present, table_full, input ready);
	modport sink (input valid, answer_yes, value, value_present, table_full, output ready);
endinterface

// ===== hw/rtl/osen_cell.sv =====
// One slot of the sorted key chain: holds a key and its valid bit.
// Compares against the broadcast key and shifts from a neighbor on insert or delete.
// Depends on osen_pkg.
module osen_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  osen_pkg::cell_ctl_t  ctl,
	input  osen_pkg::cell_stat_t left,
	input  osen_pkg::cell_stat_t right,
	output osen_pkg::cell_stat_t stat
);

	osen_pkg::key_t key_q;
	logic           valid_q;
	logic           lt;
	logic           eq;

	assign lt = valid_q && (key_q < ctl.key);
	assign eq = valid_q && (key_q == ctl.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.ins_go && !lt) begin
			valid_q <= left.lt ? 1'b1 : left.valid;
		end else if (ctl.del_go && !lt) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_go && !lt) begin
			key_q <= left.lt ? ctl.key : left.key;
		end else if (ctl.del_go && !lt) begin
			key_q <= right.key;
		end
	end

	assign stat.key   = key_q;
	assign stat.valid = valid_q;
	assign stat.lt    = lt;
	assign stat.eq    = eq;

endmodule

// ===== hw/rtl/osen_pick.sv =====
// Result picker: finds the one cell that answers a minimum, maximum,
// predecessor or successor query and gathers its key.
// Depends on osen_pkg.
module osen_pick (
	input  osen_pkg::kind_t      kind,
	input  osen_pkg::cell_stat_t stat [osen_pkg::CAPACITY],
	output osen_pkg::key_t       value,
	output logic                 present
);

	logic [osen_pkg::CAPACITY-1:0] sel;
	logic [osen_pkg::CAPACITY-1:0] gt;

	always_comb begin
		for (int i = 0; i < osen_pkg::CAPACITY; i++) begin
			gt[i] = stat[i].valid && !stat[i].lt && !stat[i].eq;
		end
	end

	always_comb begin
		sel = '0;
		unique case (kind)
			osen_pkg::OP_MIN: begin
				sel[0] = stat[0].valid;
			end
			osen_pkg::OP_MAX: begin
				for (int i = 0; i < osen_pkg::CAPACITY - 1; i++) begin
					sel[i] = stat[i].valid && !stat[i+1].valid;
				end
				sel[osen_pkg::CAPACITY-1] = stat[osen_pkg::CAPACITY-1].valid;
			end
			osen_pkg::OP_PRED: begin
				for (int i = 0; i < osen_pkg::CAPACITY - 1; i++) begin
					sel[i] = stat[i].lt && !stat[i+1].lt;
				end
				sel[osen_pkg::CAPACITY-1] = stat[osen_pkg::CAPACITY-1].lt;
			end
			osen_pkg::OP_SUCC: begin
				sel[0] = gt[0];
				for (int i = 1; i < osen_pkg::CAPACITY; i++) begin
					sel[i] = gt[i] && !gt[i-1];
				end
			end
			default: begin
				sel = '0;
			end
		endcase
	end

	always_comb begin
		value = '0;
		for (int i = 0; i < osen_pkg::CAPACITY; i++) begin
			value = value | (sel[i] ? stat[i].key : '0);
		end
	end

	assign present = |sel;

endmodule

// ===== hw/rtl/ordered_set_engine.sv =====
// Top level of the ordered set engine: command register, cell chain,
// result picker and response register. Depends on osen_pkg, osen_if,
// osen_cell and osen_pick.
//
//   port | dir  | payload                                        | role
//   cmd  | sink | kind, key                                      | one command per transfer
//   rsp  | src  | answer_yes, value, value_present, table_full   | one result per command
//
// A command is first registered; then, in the execute cycle, every cell
// compares its key in parallel, the chain shifts by one place and the picker
// selects the answer into the response register. A waiting response holds
// the execute cycle; a new command is taken once the previous one has
// executed. Reset clears the valid bits; no clearing pass.
module ordered_set_engine (
	input logic            clk,
	input logic            arst_n,
	osen_cmd_if.sink       cmd,
	osen_rsp_if.source     rsp
);

	localparam int N = osen_pkg::CAPACITY;

	logic            busy_q;
	osen_pkg::kind_t kind_q;
	osen_pkg::key_t  key_q;

	logic           rsp_valid_q;
	logic           answer_yes_q;
	osen_pkg::key_t value_q;
	logic           present_q;
	logic           full_q;

	osen_pkg::cell_ctl_t  ctl;
	osen_pkg::cell_stat_t stat [N];
	osen_pkg::cell_stat_t left_edge;
	osen_pkg::cell_stat_t right_edge;

	logic [N-1:0]   eq_vec;
	logic           found;
	logic           full;
	logic           exec;
	osen_pkg::key_t pick_value;
	logic           pick_present;

	logic           yes_d;
	logic           tfull_d;

	assign cmd.ready = !busy_q;
	assign exec      = busy_q && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_q <= cmd.kind;
			key_q  <= cmd.key;
		end
	end

	// The left boundary counts as below every key so that slot zero takes
	// an insert at the front; the right boundary feeds an empty slot.
	always_comb begin
		left_edge.key    = '0;
		left_edge.valid  = 1'b0;
		left_edge.lt     = 1'b1;
		left_edge.eq     = 1'b0;
		right_edge.key   = '0;
		right_edge.valid = 1'b0;
		right_edge.lt    = 1'b0;
		right_edge.eq    = 1'b0;
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			eq_vec[i] = stat[i].eq;
		end
	end

	assign found = |eq_vec;
	assign full  = stat[N-1].valid;

	assign ctl.key    = key_q;
	assign ctl.ins_go = exec && (kind_q == osen_pkg::OP_INSERT) && !found && !full;
	assign ctl.del_go = exec && (kind_q == osen_pkg::OP_DELETE) && found;
	assign ctl.clr    = exec && (kind_q == osen_pkg::OP_CLEAR);

	for (genvar g = 0; g < N; g++) begin : g_cell
		osen_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.left   ((g == 0) ? left_edge : stat[(g == 0) ? 0 : g - 1]),
			.right  ((g == N - 1) ? right_edge : stat[(g == N - 1) ? g : g + 1]),
			.stat   (stat[g])
		);
	end

	osen_pick u_pick (
		.kind    (kind_q),
		.stat    (stat),
		.value   (pick_value),
		.present (pick_present)
	);

	always_comb begin
		yes_d   = 1'b0;
		tfull_d = 1'b0;
		case (kind_q)
			osen_pkg::OP_INSERT: begin
				yes_d   = !found && !full;
				tfull_d = !found && full;
			end
			osen_pkg::OP_DELETE,
			osen_pkg::OP_MEMBER: begin
				yes_d = found;
			end
			default: begin
				yes_d   = 1'b0;
				tfull_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			answer_yes_q <= yes_d;
			value_q      <= pick_value;
			present_q    <= pick_present;
			full_q       <= tfull_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.answer_yes    = answer_yes_q;
	assign rsp.value         = value_q;
	assign rsp.value_present = present_q;
	assign rsp.table_full    = full_q;

endmodule
